>>> design/scdl_pkg.sv
package scdl_pkg;

   // Fixed field widths of the command and result words.
   localparam int OP_W      = 2;
   localparam int COORD_W   = 12;
   localparam int RBAND_W   = 7;
   localparam int RCOL_W    = 10;
   localparam int DATA_W    = 8;
   localparam int COUNT_W   = 10;

   // Virtual coordinate span; scaling divides by it with a shift.
   localparam int INPUT_SPAN = 4096;
   localparam int SPAN_SHIFT = $clog2(INPUT_SPAN);
   localparam int PROD_W     = COORD_W + SPAN_SHIFT + 1;

   // A scaled coordinate is below its span, so it always fits COORD_W bits.
   localparam int BAND_W = COORD_W - 3;
   localparam int DIFF_W = COORD_W + 3;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [OP_W-1:0] OP_POINT = 2'd0;
   localparam logic [OP_W-1:0] OP_LINE  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_READ  = 2'd3;

   // One prepared command as it waits between the front and back parts.
   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic [COORD_W-1:0]        x0;
      logic [COORD_W-1:0]        y0;
      logic [COORD_W-1:0]        x1;
      logic                      steep;
      logic                      step_neg;
      logic signed [DIFF_W-1:0]  d0;
      logic signed [DIFF_W-1:0]  inc_pos;
      logic signed [DIFF_W-1:0]  inc_neg;
      logic [RBAND_W-1:0]        rd_band;
      logic [RCOL_W-1:0]         rd_column;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> design/scdl_front.sv
module scdl_front #(
   parameter int COLUMNS       = 930,
   parameter int PIXELS_ACROSS = 720
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           hold,
   input  logic [scdl_pkg::OP_W-1:0]      req_opcode,
   input  logic [scdl_pkg::COORD_W-1:0]   req_start_x,
   input  logic [scdl_pkg::COORD_W-1:0]   req_start_y,
   input  logic [scdl_pkg::COORD_W-1:0]   req_end_x,
   input  logic [scdl_pkg::COORD_W-1:0]   req_end_y,
   input  logic [scdl_pkg::RBAND_W-1:0]   req_read_band,
   input  logic [scdl_pkg::RCOL_W-1:0]    req_read_column,
   output logic                           busy,
   output logic                           push_valid,
   output scdl_pkg::cmd_type              push_cmd,
   input  scdl_pkg::queue_status_type     queue_status
);
   import scdl_pkg::*;

   localparam logic [2:0] F_IDLE   = 3'd0;
   localparam logic [2:0] F_SCALE  = 3'd1;
   localparam logic [2:0] F_ORIENT = 3'd2;
   localparam logic [2:0] F_ORDER  = 3'd3;
   localparam logic [2:0] F_PUSH   = 3'd4;

   localparam logic [PROD_W-1:0] ACROSS_FACTOR = PROD_W'(PIXELS_ACROSS);
   localparam logic [PROD_W-1:0] DOWN_FACTOR   = PROD_W'(COLUMNS);

   function automatic logic [COORD_W-1:0] scale_coord(input logic [COORD_W-1:0] v,
                                                      input logic [PROD_W-1:0] factor);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(v) * factor;
      return prod[SPAN_SHIFT +: COORD_W];
   endfunction

   logic [2:0]          state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [COORD_W-1:0]  p0x_ff, p0x_in, p0y_ff, p0y_in;
   logic [COORD_W-1:0]  p1x_ff, p1x_in, p1y_ff, p1y_in;
   logic                steep_ff, steep_in;
   logic [RBAND_W-1:0]  band_ff, band_in;
   logic [RCOL_W-1:0]   col_ff, col_in;

   logic [COORD_W-1:0]       ax, ay, dx, dy;
   logic                     steep_now, step_neg;
   logic signed [DIFF_W-1:0] two_dx, two_dy;

   assign busy = (state_ff != F_IDLE) || hold;

   // Absolute spans before transposition decide steepness.
   assign ax = (p1x_ff >= p0x_ff) ? (p1x_ff - p0x_ff) : (p0x_ff - p1x_ff);
   assign ay = (p1y_ff >= p0y_ff) ? (p1y_ff - p0y_ff) : (p0y_ff - p1y_ff);
   assign steep_now = ay > ax;

   // Line setup once the ends are transposed and ordered.
   assign dx       = p1x_ff - p0x_ff;
   assign step_neg = p1y_ff < p0y_ff;
   assign dy       = step_neg ? (p0y_ff - p1y_ff) : (p1y_ff - p0y_ff);
   assign two_dx   = signed'(DIFF_W'({dx, 1'b0}));
   assign two_dy   = signed'(DIFF_W'({dy, 1'b0}));

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      p0x_in   = p0x_ff;
      p0y_in   = p0y_ff;
      p1x_in   = p1x_ff;
      p1y_in   = p1y_ff;
      steep_in = steep_ff;
      band_in  = band_ff;
      col_in   = col_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (start && !busy) begin
               op_in   = req_opcode;
               p0x_in  = req_start_x;
               p0y_in  = req_start_y;
               // A point runs as a line of one pixel.
               p1x_in  = (req_opcode == OP_POINT) ? req_start_x : req_end_x;
               p1y_in  = (req_opcode == OP_POINT) ? req_start_y : req_end_y;
               band_in = req_read_band;
               col_in  = req_read_column;
               state_in = F_SCALE;
            end
         end
         F_SCALE: begin
            p0x_in   = scale_coord(p0x_ff, ACROSS_FACTOR);
            p0y_in   = scale_coord(p0y_ff, DOWN_FACTOR);
            p1x_in   = scale_coord(p1x_ff, ACROSS_FACTOR);
            p1y_in   = scale_coord(p1y_ff, DOWN_FACTOR);
            state_in = F_ORIENT;
         end
         F_ORIENT: begin
            steep_in = steep_now;
            if (steep_now) begin
               p0x_in = p0y_ff;
               p0y_in = p0x_ff;
               p1x_in = p1y_ff;
               p1y_in = p1x_ff;
            end
            state_in = F_ORDER;
         end
         F_ORDER: begin
            if (p1x_ff < p0x_ff) begin
               p0x_in = p1x_ff;
               p0y_in = p1y_ff;
               p1x_in = p0x_ff;
               p1y_in = p0y_ff;
            end
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!queue_status.full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign push_valid         = (state_ff == F_PUSH);
   assign push_cmd.op        = op_ff;
   assign push_cmd.x0        = p0x_ff;
   assign push_cmd.y0        = p0y_ff;
   assign push_cmd.x1        = p1x_ff;
   assign push_cmd.steep     = steep_ff;
   assign push_cmd.step_neg  = step_neg;
   assign push_cmd.d0        = two_dy - signed'(DIFF_W'(dx));
   assign push_cmd.inc_pos   = two_dy - two_dx;
   assign push_cmd.inc_neg   = two_dy;
   assign push_cmd.rd_band   = band_ff;
   assign push_cmd.rd_column = col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      p0x_ff   <= p0x_in;
      p0y_ff   <= p0y_in;
      p1x_ff   <= p1x_in;
      p1y_ff   <= p1y_in;
      steep_ff <= steep_in;
      band_ff  <= band_in;
      col_ff   <= col_in;
   end

endmodule

>>> design/scdl_queue.sv
module scdl_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  scdl_pkg::cmd_type           push_cmd,
   input  logic                        pop,
   output scdl_pkg::cmd_type           head_cmd,
   output scdl_pkg::queue_status_type  status
);
   import scdl_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type             slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> design/scdl_back.sv
module scdl_back #(
   parameter int BANDS         = 90,
   parameter int COLUMNS       = 930,
   parameter int PIXELS_ACROSS = 720
) (
   input  logic                           clock,
   input  logic                           reset,
   input  scdl_pkg::cmd_type              head_cmd,
   input  scdl_pkg::queue_status_type     queue_status,
   output logic                           pop,
   output logic                           init_active,
   output logic                           rsp_strobe,
   output logic [scdl_pkg::DATA_W-1:0]    rsp_read_data,
   output logic [scdl_pkg::COUNT_W-1:0]   rsp_pixels_drawn
);
   import scdl_pkg::*;

   localparam int DEPTH  = BANDS * COLUMNS;
   localparam int AW     = $clog2(DEPTH);
   localparam int FULL_W = BAND_W + COORD_W + 1;

   localparam logic [BAND_W-1:0]  BAND_LIMIT   = BAND_W'(BANDS);
   localparam logic [COORD_W:0]   COL_LIMIT    = (COORD_W + 1)'(COLUMNS);
   localparam logic [COORD_W-1:0] ACROSS_LIMIT = COORD_W'(PIXELS_ACROSS);
   localparam logic [AW-1:0]      LAST_ADDR    = AW'(DEPTH - 1);
   localparam logic [FULL_W-1:0]  ROW_STRIDE   = FULL_W'(COLUMNS);

   localparam logic [2:0] B_SWEEP     = 3'd0;
   localparam logic [2:0] B_IDLE      = 3'd1;
   localparam logic [2:0] B_PIX_RD    = 3'd2;
   localparam logic [2:0] B_PIX_WR    = 3'd3;
   localparam logic [2:0] B_BYTE_DONE = 3'd4;

   logic [DATA_W-1:0] bitmap_mem [DEPTH];

   logic [2:0]               state_ff, state_in;
   logic                     sweep_reply_ff, sweep_reply_in;
   logic [AW-1:0]            sweep_addr_ff, sweep_addr_in;
   logic [COORD_W-1:0]       x_ff, x_in, y_ff, y_in, x1_ff, x1_in;
   logic                     steep_ff, steep_in, step_neg_ff, step_neg_in;
   logic signed [DIFF_W-1:0] d_ff, d_in, inc_pos_ff, inc_pos_in, inc_neg_ff, inc_neg_in;
   logic [COUNT_W-1:0]       count_ff, count_in, count_sum;
   logic                     hit_ff, hit_in, byte_ok_ff, byte_ok_in;
   logic [AW-1:0]            waddr_ff, waddr_in;
   logic [DATA_W-1:0]        mask_ff, mask_in, rd_data_ff;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic [DATA_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   logic [COORD_W-1:0]  pix_across, pix_down, sel_down;
   logic [BAND_W-1:0]   sel_band;
   logic                sel_across_ok, sel_ok;
   logic [FULL_W-1:0]   sel_full;
   logic [AW-1:0]       mem_raddr, mem_waddr;
   logic                mem_we;
   logic [DATA_W-1:0]   mem_wdata, pix_mask;

   assign pix_across = steep_ff ? y_ff : x_ff;
   assign pix_down   = steep_ff ? x_ff : y_ff;
   assign pix_mask   = DATA_W'(8'h80) >> pix_across[2:0];

   // The idle state addresses the byte of a read command at the queue head;
   // elsewhere the address is that of the current pixel.
   always_comb begin
      if (state_ff == B_IDLE) begin
         sel_band      = BAND_W'(head_cmd.rd_band);
         sel_down      = COORD_W'(head_cmd.rd_column);
         sel_across_ok = 1'b1;
      end else begin
         sel_band      = pix_across[COORD_W-1:3];
         sel_down      = pix_down;
         sel_across_ok = pix_across < ACROSS_LIMIT;
      end
   end

   assign sel_ok    = sel_across_ok && (sel_band < BAND_LIMIT) && ({1'b0, sel_down} < COL_LIMIT);
   assign sel_full  = FULL_W'(sel_band) * ROW_STRIDE + FULL_W'(sel_down);
   assign mem_raddr = sel_ok ? sel_full[AW-1:0] : '0;
   assign count_sum = count_ff + COUNT_W'(hit_ff);

   always_comb begin
      state_in       = state_ff;
      sweep_reply_in = sweep_reply_ff;
      sweep_addr_in  = sweep_addr_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      x1_in          = x1_ff;
      steep_in       = steep_ff;
      step_neg_in    = step_neg_ff;
      d_in           = d_ff;
      inc_pos_in     = inc_pos_ff;
      inc_neg_in     = inc_neg_ff;
      count_in       = count_ff;
      hit_in         = hit_ff;
      byte_ok_in     = byte_ok_ff;
      waddr_in       = waddr_ff;
      mask_in        = mask_ff;
      rsp_strobe_in  = 1'b0;
      rsp_data_in    = rsp_data_ff;
      rsp_count_in   = rsp_count_ff;
      mem_we         = 1'b0;
      mem_waddr      = waddr_ff;
      mem_wdata      = rd_data_ff | mask_ff;
      pop            = 1'b0;
      unique case (state_ff)
         B_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_ff;
            mem_wdata = '0;
            if (sweep_addr_ff == LAST_ADDR) begin
               state_in      = B_IDLE;
               rsp_strobe_in = sweep_reply_ff;
               rsp_data_in   = '0;
               rsp_count_in  = '0;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
            end
         end
         B_IDLE: begin
            if (!queue_status.empty) begin
               pop         = 1'b1;
               x_in        = head_cmd.x0;
               y_in        = head_cmd.y0;
               x1_in       = head_cmd.x1;
               steep_in    = head_cmd.steep;
               step_neg_in = head_cmd.step_neg;
               d_in        = head_cmd.d0;
               inc_pos_in  = head_cmd.inc_pos;
               inc_neg_in  = head_cmd.inc_neg;
               count_in    = '0;
               unique case (head_cmd.op)
                  OP_POINT, OP_LINE: begin
                     state_in = B_PIX_RD;
                  end
                  OP_CLEAR: begin
                     sweep_reply_in = 1'b1;
                     sweep_addr_in  = '0;
                     state_in       = B_SWEEP;
                  end
                  OP_READ: begin
                     byte_ok_in = sel_ok;
                     state_in   = B_BYTE_DONE;
                  end
               endcase
            end
         end
         B_PIX_RD: begin
            hit_in   = sel_ok;
            waddr_in = mem_raddr;
            mask_in  = pix_mask;
            state_in = B_PIX_WR;
         end
         B_PIX_WR: begin
            mem_we   = hit_ff;
            count_in = count_sum;
            if (x_ff == x1_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '0;
               rsp_count_in  = count_sum;
               state_in      = B_IDLE;
            end else begin
               x_in = x_ff + 1'b1;
               if (!d_ff[DIFF_W-1]) begin
                  y_in = step_neg_ff ? (y_ff - 1'b1) : (y_ff + 1'b1);
                  d_in = d_ff + inc_pos_ff;
               end else begin
                  d_in = d_ff + inc_neg_ff;
               end
               state_in = B_PIX_RD;
            end
         end
         B_BYTE_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = byte_ok_ff ? rd_data_ff : '0;
            rsp_count_in  = '0;
            state_in      = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= bitmap_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= B_SWEEP;
         sweep_reply_ff <= 1'b0;
         sweep_addr_ff  <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sweep_reply_ff <= sweep_reply_in;
         sweep_addr_ff  <= sweep_addr_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      x1_ff        <= x1_in;
      steep_ff     <= steep_in;
      step_neg_ff  <= step_neg_in;
      d_ff         <= d_in;
      inc_pos_ff   <= inc_pos_in;
      inc_neg_ff   <= inc_neg_in;
      count_ff     <= count_in;
      hit_ff       <= hit_in;
      byte_ok_ff   <= byte_ok_in;
      waddr_ff     <= waddr_in;
      mask_ff      <= mask_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign init_active      = (state_ff == B_SWEEP) && !sweep_reply_ff;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_pixels_drawn = rsp_count_ff;

   // Every result word is a single-cycle strobe; the back end is idle while it is high.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held for more than one cycle");

   // A pixel write always uses the byte read in the cycle before.
   a_read_before_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_PIX_WR) |-> ($past(state_ff) == B_PIX_RD))
      else $error("pixel write without preceding read");

   // The stepping coordinate never runs past the far end of the line.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_PIX_RD || state_ff == B_PIX_WR) |-> (x_ff <= x1_ff))
      else $error("line stepping passed its end point");

   // The clearing pass after reset ends only by going idle.
   a_init_exit: assert property (@(posedge clock) disable iff (reset)
      init_active |=> (init_active || state_ff == B_IDLE))
      else $error("clearing pass after reset left to a wrong state");

endmodule

>>> design/scaled_line_draw_bitmap_core.sv
// Draw engine over a banded 1-bit bitmap (BANDS bands of COLUMNS bytes, one
// pixel per bit, pixel (across, down) at bit 128 >> (across & 7) of byte
// [across >> 3][down]). Each command word is a point, a line, a clear or a
// one-byte read, and each gives exactly one result word on rsp_strobe, which
// is high for a single cycle; the receiver cannot stall it, so it must take
// every strobed word. A command is taken when start is high and busy is low.
// After reset the engine zeroes the whole bitmap one byte per cycle, and busy
// stays high until that pass ends. The front end then takes each command
// through five steps (capture, coordinate scaling, steep transposition, end
// ordering, hand-off) before busy drops again, and a two-entry queue lets it
// run ahead of the back end. The back end owns the bitmap memory, which has
// one read port and one write port, and runs one command at a time: a point
// or line reads and then writes back the byte of each pixel, with
// max(|delta across|, |delta down|) + 1 pixels per line, a read fetches one
// byte, and a clear writes one byte per cycle over the whole bitmap.
// Pixels that fall outside the bitmap are skipped and not counted.
module scaled_line_draw_bitmap_core #(
   parameter int BANDS         = 90,
   parameter int COLUMNS       = 930,
   parameter int PIXELS_ACROSS = 720
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [scdl_pkg::OP_W-1:0]      req_opcode,
   input  logic [scdl_pkg::COORD_W-1:0]   req_start_x,
   input  logic [scdl_pkg::COORD_W-1:0]   req_start_y,
   input  logic [scdl_pkg::COORD_W-1:0]   req_end_x,
   input  logic [scdl_pkg::COORD_W-1:0]   req_end_y,
   input  logic [scdl_pkg::RBAND_W-1:0]   req_read_band,
   input  logic [scdl_pkg::RCOL_W-1:0]    req_read_column,
   output logic                           rsp_strobe,
   output logic [scdl_pkg::DATA_W-1:0]    rsp_read_data,
   output logic [scdl_pkg::COUNT_W-1:0]   rsp_pixels_drawn
);
   import scdl_pkg::*;

   // Prepared commands flow from the front end through the queue.
   logic              push_valid;
   cmd_type           push_cmd;
   cmd_type           head_cmd;
   queue_status_type  queue_status;
   logic              pop;

   // High during the clearing pass after reset; no command is taken then.
   logic              init_active;

   scdl_front #(
      .COLUMNS       (COLUMNS),
      .PIXELS_ACROSS (PIXELS_ACROSS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .hold            (init_active),
      .req_opcode      (req_opcode),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_read_band   (req_read_band),
      .req_read_column (req_read_column),
      .busy            (busy),
      .push_valid      (push_valid),
      .push_cmd        (push_cmd),
      .queue_status    (queue_status)
   );

   scdl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (queue_status)
   );

   // The back end executes one command at a time against the bitmap memory
   // and drives the result word registers directly.
   scdl_back #(
      .BANDS         (BANDS),
      .COLUMNS       (COLUMNS),
      .PIXELS_ACROSS (PIXELS_ACROSS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_cmd         (head_cmd),
      .queue_status     (queue_status),
      .pop              (pop),
      .init_active      (init_active),
      .rsp_strobe       (rsp_strobe),
      .rsp_read_data    (rsp_read_data),
      .rsp_pixels_drawn (rsp_pixels_drawn)
   );

endmodule
